@@ rtl/pcbt_pkg.sv @@
// shared types and constants for the periodic callback timer table
// no dependencies; used by pcbt_cell and periodic_callback_timer_table
package pcbt_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int MAX_REPORTS   = 16;
    localparam int REP_W         = $clog2(MAX_REPORTS + 1);
    localparam int CMD_W         = 2;
    localparam int IVAL_W        = 16;
    localparam int ID_W          = 5;
    localparam int TICK_W        = 32;

    localparam logic [CMD_W-1:0] CMD_REGISTER   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UNREGISTER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK       = 2'd2;

    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_FIRE  = 1'b1;

    // request walking down the cell chain
    typedef struct packed {
        logic              valid;
        logic [CMD_W-1:0]  cmd;
        logic [IVAL_W-1:0] interval;
        logic [ID_W-1:0]   sid;
        logic              claimed;
        logic [ID_W-1:0]   claim_id;
    } token_t;

    typedef struct packed {
        logic            fire;
        logic [ID_W-1:0] id;
    } fire_t;

endpackage

@@ rtl/periodic_callback_timer_table.sv @@
// periodic callback timer table: one request walks a chain of NUM_SLOTS slot cells
// register reply and last fire are registered at the output once the request has passed tok0_reg
// and every cell; earlier fires leave as the walk reaches the next due slot, at most one per cycle
// requests: one at a time; s_axis_tready stays low until the request leaves the last cell
// reset: all slots free, tick count zero, output empty; interval and counter stores not cleared
// depends on pcbt_pkg and pcbt_cell
module periodic_callback_timer_table #(
    parameter int NUM_SLOTS = pcbt_pkg::NUM_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // command[1:0], interval_ticks[17:2], slot_id[22:18]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // result_id[4:0], tick_count[36:5]
    output logic        m_axis_tuser,  // reply_kind
    output logic        m_axis_tlast
);
    import pcbt_pkg::*;

    token_t            tok_w [0:NUM_SLOTS];
    fire_t             fires [1:NUM_SLOTS];

    token_t            tok0_reg, tok0_next;
    logic              busy_reg, busy_next;
    logic [TICK_W-1:0] elapsed_reg, elapsed_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]   pend_id_reg, pend_id_next;
    logic [REP_W-1:0]  nrep_reg, nrep_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_kind_reg, out_kind_next;
    logic              out_last_reg, out_last_next;
    logic [ID_W-1:0]   out_id_reg, out_id_next;
    logic [TICK_W-1:0] out_tick_reg, out_tick_next;

    logic              advance;
    logic              accept;
    logic              fire_any;
    logic [ID_W-1:0]   fire_id;
    token_t            tok_end;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && !busy_reg;
    assign s_axis_tready = !busy_reg;
    assign tok_w[0]      = tok0_reg;
    assign tok_end       = tok_w[NUM_SLOTS];

    for (genvar g = 1; g <= NUM_SLOTS; g++)
    begin : g_cell
        pcbt_cell #(
            .ID (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .tok_in  (tok_w[g-1]),
            .tok_out (tok_w[g]),
            .fire    (fires[g])
        );
    end

    // only the cell holding the request can fire
    always_comb
    begin
        fire_any = 1'b0;
        fire_id  = '0;
        for (int i = 1; i <= NUM_SLOTS; i++)
        begin
            fire_any = fire_any | fires[i].fire;
            fire_id  = fire_id | fires[i].id;
        end
    end

    always_comb
    begin
        tok0_next       = tok0_reg;
        busy_next       = busy_reg;
        elapsed_next    = elapsed_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        nrep_next       = nrep_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_kind_next   = out_kind_reg;
        out_last_next   = out_last_reg;
        out_id_next     = out_id_reg;
        out_tick_next   = out_tick_reg;

        if (accept)
        begin
            tok0_next.valid    = 1'b1;
            tok0_next.cmd      = s_axis_tdata[1:0];
            tok0_next.interval = s_axis_tdata[17:2];
            tok0_next.sid      = s_axis_tdata[22:18];
            tok0_next.claimed  = 1'b0;
            tok0_next.claim_id = '0;
            busy_next          = 1'b1;
            nrep_next          = '0;
            pend_valid_next    = 1'b0;
            if (s_axis_tdata[1:0] == CMD_TICK)
                elapsed_next = elapsed_reg + TICK_W'(1);
        end
        else if (advance)
            tok0_next.valid = 1'b0;

        if (advance && fire_any && nrep_reg < REP_W'(MAX_REPORTS))
        begin
            nrep_next       = nrep_reg + REP_W'(1);
            pend_valid_next = 1'b1;
            pend_id_next    = fire_id;
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_kind_next  = KIND_FIRE;
                out_last_next  = 1'b0;
                out_id_next    = pend_id_reg;
                out_tick_next  = elapsed_reg;
            end
        end

        if (advance && tok_end.valid)
        begin
            busy_next = 1'b0;
            if (tok_end.cmd == CMD_REGISTER)
            begin
                out_valid_next = 1'b1;
                out_kind_next  = KIND_REPLY;
                out_last_next  = 1'b1;
                out_id_next    = tok_end.claimed ? tok_end.claim_id : '0;
                out_tick_next  = '0;
            end
            else if (tok_end.cmd == CMD_TICK && pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_kind_next   = KIND_FIRE;
                out_last_next   = 1'b1;
                out_id_next     = pend_id_reg;
                out_tick_next   = elapsed_reg;
                pend_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok0_reg       <= '0;
            busy_reg       <= 1'b0;
            elapsed_reg    <= '0;
            pend_valid_reg <= 1'b0;
            nrep_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            tok0_reg       <= tok0_next;
            busy_reg       <= busy_next;
            elapsed_reg    <= elapsed_next;
            pend_valid_reg <= pend_valid_next;
            nrep_reg       <= nrep_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_id_reg  <= pend_id_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
        out_id_reg   <= out_id_next;
        out_tick_reg <= out_tick_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_tick_reg, out_id_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

@@ rtl/pcbt_cell.sv @@
// one timer slot: active flag, interval and down counter
// depends on pcbt_pkg; passes the request on to the next cell each step
module pcbt_cell #(
    parameter int ID = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  pcbt_pkg::token_t tok_in,
    output pcbt_pkg::token_t tok_out,
    output pcbt_pkg::fire_t  fire
);
    import pcbt_pkg::*;

    localparam logic [ID_W-1:0] MY_ID = ID_W'(ID);

    logic              active_reg, active_next;
    logic [IVAL_W-1:0] interval_reg, interval_next;
    logic [IVAL_W-1:0] counter_reg, counter_next;
    logic [IVAL_W-1:0] dec;
    token_t            tok_reg, tok_next;

    always_comb
    begin
        active_next   = active_reg;
        interval_next = interval_reg;
        counter_next  = counter_reg;
        tok_next      = tok_in;
        fire          = '0;
        dec           = counter_reg - IVAL_W'(1);
        if (tok_in.valid)
        begin
            case (tok_in.cmd)
                CMD_REGISTER:
                begin
                    if (!tok_in.claimed && !active_reg)
                    begin
                        active_next       = 1'b1;
                        interval_next     = tok_in.interval;
                        counter_next      = tok_in.interval;
                        tok_next.claimed  = 1'b1;
                        tok_next.claim_id = MY_ID;
                    end
                end
                CMD_UNREGISTER:
                begin
                    if (32'(tok_in.sid) == ID)
                        active_next = 1'b0;
                end
                CMD_TICK:
                begin
                    if (active_reg && interval_reg != '0)
                    begin
                        if (dec == '0)
                        begin
                            counter_next = interval_reg;
                            fire.fire    = 1'b1;
                            fire.id      = MY_ID;
                        end
                        else
                            counter_next = dec;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            tok_reg    <= '0;
        end
        else if (advance)
        begin
            active_reg <= active_next;
            tok_reg    <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            interval_reg <= interval_next;
            counter_reg  <= counter_next;
        end
    end

    assign tok_out = tok_reg;

endmodule
